FILE: rtl/nnact_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nnact_pkg;

  localparam int FIELD_W       = 24;
  localparam int FRAC_BITS     = 16;
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int X_W           = FIELD_W + 24 - FRAC_BITS;
  localparam int OUT_SH        = 30 - FRAC_BITS;

  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [30:0] LN2_Q30   = 31'd744261118;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic signed [24:0] ALPHA_Q30 = 25'sd10737418;
  localparam logic [29:0] EXP_LIMIT = 30'd32 << 24;
  localparam logic [29:0] CLAMP20   = 30'd20 << 24;

  localparam logic signed [63:0] ONE_F     = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] FIELD_MAX = (64'sd1 <<< (FIELD_W - 1)) - 64'sd1;
  localparam logic signed [63:0] FIELD_MIN = -(64'sd1 <<< (FIELD_W - 1));

  typedef enum logic [2:0] {
    MODE_SIGMOID = 3'd0,
    MODE_TANH    = 3'd1,
    MODE_RELU    = 3'd2,
    MODE_SWISH   = 3'd3,
    MODE_LEAKY   = 3'd4,
    MODE_ELU     = 3'd5
  } act_mode_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_OUT,
    SH_FULL
  } rnd_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] nl;
    logic [31:0] q;
    logic [31:0] d;
  } div_t;

  typedef logic [30:0] exp_tab_t [TABLE_ENTRIES + 1];

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] acc;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      a    = (64'(k) * 64'(LN2_Q30)) / TABLE_ENTRIES;
      term = 64'(ONE_Q30);
      acc  = 64'(ONE_Q30);
      for (int i = 1; i <= 24; i++) begin
        term = ((term * a) >> 30) / 64'(i);
        if (i[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      tab[k] = acc[30:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int sh);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [FIELD_W-1:0] sat_field(input logic signed [63:0] v);
    logic [FIELD_W-1:0] r;
    if (v > FIELD_MAX) begin
      r = {1'b0, {(FIELD_W - 1){1'b1}}};
    end else if (v < FIELD_MIN) begin
      r = {1'b1, {(FIELD_W - 1){1'b0}}};
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/nn_activation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Activation unit: each z_value beat (signed Q8.16) yields one beat carrying the activation
// and its derivative for the mode held in the act_mode register (0 sigmoid, 1 tanh, 2 relu,
// 3 swish, 4 leaky relu, 5 elu); writes above 5 are dropped and the mode must only change
// while no beat is in flight. The pipeline is 18 register stages deep, and one beat per
// cycle is sustained while out_stall is low. The depth is set by the exp interpolation
// stages and the 32-bit reciprocal divider, which resolves four quotient bits per stage
// over eight stages. A stall on the output holds only the stages behind it that are full;
// empty stages keep filling, and cfg_ready is always high.
module nn_activation_unit
  import nnact_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire signed [FIELD_W-1:0]   z_value,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic signed [FIELD_W-1:0] act_value,
  output logic signed [FIELD_W-1:0] deriv_value,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [2:0]                  cfg_data
);

  localparam int S_IN   = 1;
  localparam int S_LOG  = 2;
  localparam int S_TAB  = 3;
  localparam int S_INT  = 4;
  localparam int S_EXP  = 5;
  localparam int S_DSET = 6;
  localparam int DIV_ST = 8;
  localparam int DIV_BITS = 32 / DIV_ST;
  localparam int S_QUO  = S_DSET + DIV_ST;
  localparam int S_SIG  = S_QUO + 1;
  localparam int S_PROD = S_SIG + 1;
  localparam int S_SEL  = S_PROD + 1;
  localparam int NST    = S_SEL + 1;

  act_mode_t act_mode;

  logic [NST:1] vld;
  logic [NST:1] rdy;

  logic signed [FIELD_W-1:0] z_p [S_IN:S_PROD];
  logic [36:0] y_r    [2];
  logic [30:0] hi_r   [2];
  logic [30:0] diff_r [2];
  logic [29:0] frac_r [2];
  logic [6:0]  n_r    [2];
  logic [30:0] pq_r   [2];
  logic [30:0] hi4_r  [2];
  logic [6:0]  n4_r   [2];
  logic [30:0] e_p    [S_EXP:S_PROD][2];
  div_t        div_p  [0:DIV_ST];

  logic [30:0]        s15;
  logic [30:0]        m15;
  logic [30:0]        q15;
  logic signed [55:0] zs15;
  logic [30:0]        s16;
  logic [30:0]        m16;
  logic [30:0]        q16;
  logic signed [55:0] zs16;
  logic signed [55:0] zsd16;
  logic signed [55:0] za16;
  logic signed [63:0] act_raw;
  logic signed [63:0] der_raw;
  rnd_t               act_sh;
  rnd_t               der_sh;

  logic [FIELD_W-1:0] mag_c;
  logic [X_W-1:0]     x_c;
  logic [X_W:0]       x2_c;
  logic [29:0]        arg_c [2];
  logic [60:0]        ylog_c [2];
  logic [IDX_W:0]     idx_c [2];
  logic [60:0]        pint_c [2];
  logic [30:0]        e_c [2];
  logic [31:0]        d_c;
  logic [63:0]        num_c;
  logic [30:0]        q_c;
  logic [30:0]        s_c;
  logic [61:0]        m_c;
  logic signed [63:0] act_raw_c;
  logic signed [63:0] der_raw_c;
  rnd_t               act_sh_c;
  rnd_t               der_sh_c;
  logic               zpos_c;

  function automatic div_t div_step(input div_t cur);
    div_t        nx;
    logic [31:0] sh;
    nx = cur;
    for (int b = 0; b < DIV_BITS; b++) begin
      sh = {nx.rem[30:0], nx.nl[31]};
      nx.nl = nx.nl << 1;
      if (sh >= nx.d) begin
        nx.rem = sh - nx.d;
        nx.q   = {nx.q[30:0], 1'b1};
      end else begin
        nx.rem = sh;
        nx.q   = {nx.q[30:0], 1'b0};
      end
    end
    return nx;
  endfunction

  function automatic logic [FIELD_W-1:0] finish(input logic signed [63:0] v, input rnd_t k);
    logic signed [63:0] r;
    case (k)
      SH_OUT:  r = round_shift(v, OUT_SH);
      SH_FULL: r = round_shift(v, 30);
      default: r = v;
    endcase
    return sat_field(r);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_mode <= MODE_SIGMOID;
    end else if (cfg_valid && cfg_ready && cfg_data <= 3'(MODE_ELU)) begin
      act_mode <= act_mode_t'(cfg_data);
    end
  end

  always_comb begin
    rdy[NST] = !vld[NST] || !out_stall;
    for (int k = NST - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = !rdy[S_IN];
  assign out_valid = vld[NST];

  always_ff @(posedge clk) begin
    if (rdy[S_IN]) begin
      z_p[S_IN] <= z_value;
    end
    for (int k = S_IN + 1; k <= S_PROD; k++) begin
      if (rdy[k]) begin
        z_p[k] <= z_p[k-1];
      end
    end
  end

  // exp argument and log2(e) scaling
  always_comb begin
    mag_c = z_p[S_IN][FIELD_W-1] ? FIELD_W'(-z_p[S_IN]) : FIELD_W'(z_p[S_IN]);
    x_c   = X_W'(mag_c) << (24 - FRAC_BITS);
    x2_c  = {x_c, 1'b0};
    if (act_mode == MODE_TANH) begin
      arg_c[0] = (x2_c > (X_W + 1)'(EXP_LIMIT)) ? EXP_LIMIT : x2_c[29:0];
    end else begin
      arg_c[0] = (x_c > X_W'(CLAMP20)) ? CLAMP20 : x_c[29:0];
    end
    arg_c[1] = (x_c > X_W'(EXP_LIMIT)) ? EXP_LIMIT : x_c[29:0];
    for (int l = 0; l < 2; l++) begin
      ylog_c[l] = 61'(arg_c[l]) * 61'(LOG2E_Q30);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_LOG]) begin
      for (int l = 0; l < 2; l++) begin
        y_r[l] <= ylog_c[l][60:24];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      idx_c[l] = {1'b0, y_r[l][29:30-IDX_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_TAB]) begin
      for (int l = 0; l < 2; l++) begin
        hi_r[l]   <= EXP_TAB[idx_c[l]];
        diff_r[l] <= EXP_TAB[idx_c[l]] - EXP_TAB[idx_c[l] + (IDX_W + 1)'(1)];
        frac_r[l] <= {y_r[l][29-IDX_W:0], {IDX_W{1'b0}}};
        n_r[l]    <= y_r[l][36:30];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pint_c[l] = 61'(diff_r[l]) * 61'(frac_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_INT]) begin
      for (int l = 0; l < 2; l++) begin
        pq_r[l]  <= pint_c[l][60:30];
        hi4_r[l] <= hi_r[l];
        n4_r[l]  <= n_r[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      e_c[l] = (hi4_r[l] - pq_r[l]) >> n4_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_EXP]) begin
      e_p[S_EXP] <= e_c;
    end
    for (int k = S_EXP + 1; k <= S_PROD; k++) begin
      if (rdy[k]) begin
        e_p[k] <= e_p[k-1];
      end
    end
  end

  // reciprocal setup: sigmoid 1/(1+e), tanh (1-e)/(1+e), both rounded to nearest
  always_comb begin
    d_c = 32'(ONE_Q30) + 32'(e_p[S_EXP][0]);
    if (act_mode == MODE_TANH) begin
      num_c = (64'(ONE_Q30 - e_p[S_EXP][0]) << 30) + 64'(d_c >> 1);
    end else begin
      num_c = (64'd1 << 60) + 64'(d_c >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_DSET]) begin
      div_p[0] <= '{rem: num_c[63:32], nl: num_c[31:0], q: 32'd0, d: d_c};
    end
    for (int j = 1; j <= DIV_ST; j++) begin
      if (rdy[S_DSET+j]) begin
        div_p[j] <= div_step(div_p[j-1]);
      end
    end
  end

  always_comb begin
    q_c = div_p[DIV_ST].q[30:0];
    s_c = z_p[S_QUO][FIELD_W-1] ? ONE_Q30 - q_c : q_c;
    if (act_mode == MODE_TANH) begin
      m_c = 62'(q_c) * 62'(q_c);
    end else begin
      m_c = 62'(s_c) * 62'(ONE_Q30 - s_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_SIG]) begin
      s15  <= s_c;
      q15  <= q_c;
      m15  <= m_c[60:30];
      zs15 <= $signed(z_p[S_QUO]) * $signed({1'b0, s_c});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_PROD]) begin
      s16   <= s15;
      q16   <= q15;
      m16   <= m15;
      zs16  <= zs15;
      zsd16 <= $signed(z_p[S_SIG]) * $signed({1'b0, m15});
      za16  <= $signed(z_p[S_SIG]) * ALPHA_Q30;
    end
  end

  always_comb begin
    zpos_c    = !z_p[S_PROD][FIELD_W-1] && (z_p[S_PROD] != '0);
    act_raw_c = '0;
    der_raw_c = '0;
    act_sh_c  = SH_NONE;
    der_sh_c  = SH_NONE;
    unique case (act_mode)
      MODE_SIGMOID: begin
        act_raw_c = $signed(64'(s16));
        der_raw_c = $signed(64'(m16));
        act_sh_c  = SH_OUT;
        der_sh_c  = SH_OUT;
      end
      MODE_TANH: begin
        act_raw_c = z_p[S_PROD][FIELD_W-1] ? -$signed(64'(q16)) : $signed(64'(q16));
        der_raw_c = $signed(64'(ONE_Q30)) - $signed(64'(m16));
        act_sh_c  = SH_OUT;
        der_sh_c  = SH_OUT;
      end
      MODE_RELU: begin
        act_raw_c = zpos_c ? 64'(z_p[S_PROD]) : 64'sd0;
        der_raw_c = zpos_c ? ONE_F : 64'sd0;
      end
      MODE_SWISH: begin
        act_raw_c = 64'(zs16);
        der_raw_c = $signed(64'(s16)) + round_shift(64'(zsd16), FRAC_BITS);
        act_sh_c  = SH_FULL;
        der_sh_c  = SH_OUT;
      end
      MODE_LEAKY: begin
        if (zpos_c) begin
          act_raw_c = 64'(z_p[S_PROD]);
          der_raw_c = ONE_F;
        end else begin
          act_raw_c = 64'(za16);
          der_raw_c = 64'(ALPHA_Q30);
          act_sh_c  = SH_FULL;
          der_sh_c  = SH_OUT;
        end
      end
      MODE_ELU: begin
        if (zpos_c) begin
          act_raw_c = 64'(z_p[S_PROD]);
          der_raw_c = ONE_F;
        end else begin
          act_raw_c = $signed(64'(e_p[S_PROD][0])) - $signed(64'(ONE_Q30));
          der_raw_c = $signed(64'(e_p[S_PROD][1]));
          act_sh_c  = SH_OUT;
          der_sh_c  = SH_OUT;
        end
      end
      default: begin
        act_raw_c = '0;
        der_raw_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[S_SEL]) begin
      act_raw <= act_raw_c;
      der_raw <= der_raw_c;
      act_sh  <= act_sh_c;
      der_sh  <= der_sh_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST]) begin
      act_value   <= finish(act_raw, act_sh);
      deriv_value <= finish(der_raw, der_sh);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/nnact_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module nnact_chk
  import nnact_pkg::*;
(
  input wire                      clk,
  input wire                      rst,
  input wire                      in_stall,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire signed [FIELD_W-1:0] act_value,
  input wire signed [FIELD_W-1:0] deriv_value
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_empty_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage empty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(act_value) && $stable(deriv_value))
    else $error("stalled output beat changed");

endmodule

bind nn_activation_unit nnact_chk u_nnact_chk (.*);
`default_nettype wire
